// ----- hw/rtl/wav_header_parser_defines.svh -----
// ----------------------------------------------------------------------------
// wav header parser assertion macros
// shared concurrent assertion forms used by the parser's checks
// ----------------------------------------------------------------------------
`ifndef WAV_HEADER_PARSER_DEFINES_SVH
`define WAV_HEADER_PARSER_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define WHP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("whp assertion failed");

// next-cycle implication, disabled while reset is high
`define WHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("whp assertion failed");

`endif

// ----- hw/rtl/whp_pkg.sv -----
// ----------------------------------------------------------------------------
// whp_pkg
// types and constants of the wav header parser
// ----------------------------------------------------------------------------
package whp_pkg;

   // chunk tags as little-endian words
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [15:0] FMT_PCM      = 16'h0001;
   localparam logic [15:0] FMT_ADPCM    = 16'h0011;
   localparam logic [31:0] FMT_MIN_SIZE = 32'd16;

   localparam logic [15:0] BITS_4  = 16'd4;
   localparam logic [15:0] BITS_8  = 16'd8;
   localparam logic [15:0] BITS_16 = 16'd16;
   localparam logic [15:0] MAX_CHANNELS = 16'd2;

   localparam logic [31:0] CHUNK_FIELD_BYTES = 32'd4;
   localparam logic [32:0] RIFF_HEADER_BYTES = 33'd8;

   // last byte of each fixed header field that the parser reads
   localparam logic [31:0] POS_RIFF_TAG  = 32'd3;
   localparam logic [31:0] POS_RIFF_SIZE = 32'd7;
   localparam logic [31:0] POS_WAVE_TAG  = 32'd11;
   localparam logic [31:0] POS_FMT_TAG   = 32'd15;
   localparam logic [31:0] POS_FMT_SIZE  = 32'd19;
   localparam logic [31:0] POS_FORMAT    = 32'd21;
   localparam logic [31:0] POS_CHANNELS  = 32'd23;
   localparam logic [31:0] POS_RATE      = 32'd27;
   localparam logic [31:0] POS_ALIGN     = 32'd33;
   localparam logic [31:0] POS_BITS      = 32'd35;

   // parse phases
   localparam logic [2:0] PH_HEADER     = 3'd0;
   localparam logic [2:0] PH_FMT_SKIP   = 3'd1;
   localparam logic [2:0] PH_TAG        = 3'd2;
   localparam logic [2:0] PH_SIZE_DATA  = 3'd3;
   localparam logic [2:0] PH_SIZE_OTHER = 3'd4;
   localparam logic [2:0] PH_SKIP       = 3'd5;
   localparam logic [2:0] PH_END        = 3'd6;

   // status codes
   localparam logic [3:0] ST_BUSY         = 4'd0;
   localparam logic [3:0] ST_DONE         = 4'd1;
   localparam logic [3:0] ST_BAD_RIFF     = 4'd2;
   localparam logic [3:0] ST_BAD_WAVE     = 4'd3;
   localparam logic [3:0] ST_BAD_FMT      = 4'd4;
   localparam logic [3:0] ST_BAD_BITS     = 4'd5;
   localparam logic [3:0] ST_BAD_FORMAT   = 4'd6;
   localparam logic [3:0] ST_BAD_CHANNELS = 4'd7;
   localparam logic [3:0] ST_NO_DATA      = 4'd8;

   // sample format codes
   localparam logic [1:0] SF_PCM8  = 2'd0;
   localparam logic [1:0] SF_PCM16 = 2'd1;
   localparam logic [1:0] SF_ADPCM = 2'd2;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       first_byte;
      logic       last_byte;
   } whp_entry_type;

   typedef struct packed {
      logic          valid;
      whp_entry_type entry;
   } whp_qout_type;

   typedef struct packed {
      logic [2:0]  phase;
      logic [31:0] byte_pos;
      logic [31:0] field_shift;
      logic [32:0] riff_limit;
      logic [31:0] skip_count;
      logic [15:0] format_code;
      logic [15:0] channel_count;
      logic [31:0] rate;
      logic [15:0] align;
      logic [15:0] bits;
      logic [31:0] data_offset;
      logic [31:0] data_size;
      logic [3:0]  status;
   } whp_state_type;

   localparam whp_state_type STATE_RESET = '{
      phase:         PH_HEADER,
      byte_pos:      32'd0,
      field_shift:   32'd0,
      riff_limit:    RIFF_HEADER_BYTES,
      skip_count:    32'd0,
      format_code:   16'd0,
      channel_count: 16'd0,
      rate:          32'd0,
      align:         16'd0,
      bits:          16'd0,
      data_offset:   32'd0,
      data_size:     32'd0,
      status:        ST_BUSY
   };

   typedef struct packed {
      logic [3:0]  status;
      logic [1:0]  sample_format;
      logic        is_stereo;
      logic [31:0] rate_hz;
      logic [15:0] align_bytes;
      logic [15:0] bits_each;
      logic [31:0] payload_offset;
      logic [31:0] payload_length;
   } whp_result_type;

endpackage

// ----- hw/rtl/whp_if.sv -----
// ----------------------------------------------------------------------------
// whp channel interfaces
// valid/ready channels for file bytes in and parse results out
// ----------------------------------------------------------------------------
interface whp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] file_byte;
   logic       first_byte;
   logic       last_byte;

   modport source (output valid, output file_byte, output first_byte,
                   output last_byte, input ready);
   modport sink   (input valid, input file_byte, input first_byte,
                   input last_byte, output ready);
endinterface

interface whp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [1:0]  sample_format;
   logic        is_stereo;
   logic [31:0] rate_hz;
   logic [15:0] align_bytes;
   logic [15:0] bits_each;
   logic [31:0] payload_offset;
   logic [31:0] payload_length;

   modport source (output valid, output status, output sample_format,
                   output is_stereo, output rate_hz, output align_bytes,
                   output bits_each, output payload_offset,
                   output payload_length, input ready);
   modport sink   (input valid, input status, input sample_format,
                   input is_stereo, input rate_hz, input align_bytes,
                   input bits_each, input payload_offset,
                   input payload_length, output ready);
endinterface

// ----- hw/rtl/whp_queue.sv -----
// ----------------------------------------------------------------------------
// whp_queue
// front end: takes byte transfers and holds them for the parse engine
// ----------------------------------------------------------------------------
module whp_queue #(
   parameter int DEPTH = whp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   whp_req_if.sink               req,
   output whp_pkg::whp_qout_type q_out,
   input  logic                  q_pop
);
   import whp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   whp_entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push;

   assign req.ready = (count_ff != CNT_FULL);
   assign push      = req.valid && req.ready;

   assign q_out.valid = (count_ff != '0);
   assign q_out.entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{file_byte:  req.file_byte,
                                 first_byte: req.first_byte,
                                 last_byte:  req.last_byte};
      end
   end

endmodule

// ----- hw/rtl/whp_parse.sv -----
// ----------------------------------------------------------------------------
// whp_parse
// back end: riff/wave parse engine, one byte per cycle unless the result side stalls, registered result
// ----------------------------------------------------------------------------
module whp_parse (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic                  csr_write_data,
   input  whp_pkg::whp_qout_type q_out,
   output logic                  q_pop,
   whp_rsp_if.source             rsp
);
   import whp_pkg::*;

   whp_state_type  st_ff, st_in;
   whp_state_type  cur;
   whp_result_type res_ff, res_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           adpcm_enable_ff, adpcm_enable_in;

   logic [31:0] acc;
   logic [31:0] pos_next;
   logic [31:0] skip_dec;
   logic        hdr_past_end;
   logic        done;

   assign q_pop = q_out.valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      cur   = q_out.entry.first_byte ? STATE_RESET : st_ff;
      st_in = cur;
      acc      = {q_out.entry.file_byte, cur.field_shift[31:8]};
      pos_next = (cur.byte_pos == '1) ? cur.byte_pos : cur.byte_pos + 32'd1;
      skip_dec = cur.skip_count - 32'd1;
      hdr_past_end = ({1'b0, pos_next} >= cur.riff_limit);

      if (cur.phase != PH_END) begin
         st_in.field_shift = acc;
         unique case (cur.phase)
            PH_HEADER: begin
               case (cur.byte_pos)
                  POS_RIFF_TAG: begin
                     if (acc != TAG_RIFF) begin
                        st_in.status = ST_BAD_RIFF;
                        st_in.phase  = PH_END;
                     end
                  end
                  POS_RIFF_SIZE: st_in.riff_limit = {1'b0, acc} + RIFF_HEADER_BYTES;
                  POS_WAVE_TAG: begin
                     if (acc != TAG_WAVE) begin
                        st_in.status = ST_BAD_WAVE;
                        st_in.phase  = PH_END;
                     end
                  end
                  POS_FMT_TAG: begin
                     if (acc != TAG_FMT) begin
                        st_in.status = ST_BAD_FMT;
                        st_in.phase  = PH_END;
                     end
                  end
                  POS_FMT_SIZE: begin
                     if (acc < FMT_MIN_SIZE) begin
                        st_in.status = ST_BAD_FMT;
                        st_in.phase  = PH_END;
                     end else begin
                        // remaining fmt bytes, rounded up to even
                        st_in.skip_count = acc - FMT_MIN_SIZE + {31'd0, acc[0]};
                     end
                  end
                  POS_FORMAT:   st_in.format_code   = acc[31:16];
                  POS_CHANNELS: st_in.channel_count = acc[31:16];
                  POS_RATE:     st_in.rate          = acc;
                  POS_ALIGN:    st_in.align         = acc[31:16];
                  POS_BITS: begin
                     st_in.bits = acc[31:16];
                     if (cur.format_code == FMT_PCM) begin
                        if (acc[31:16] != BITS_8 && acc[31:16] != BITS_16) begin
                           st_in.status = ST_BAD_BITS;
                           st_in.phase  = PH_END;
                        end
                     end else if (cur.format_code == FMT_ADPCM && adpcm_enable_ff) begin
                        if (acc[31:16] != BITS_4) begin
                           st_in.status = ST_BAD_BITS;
                           st_in.phase  = PH_END;
                        end
                     end else begin
                        st_in.status = ST_BAD_FORMAT;
                        st_in.phase  = PH_END;
                     end
                     if (st_in.phase != PH_END) begin
                        if (cur.channel_count > MAX_CHANNELS) begin
                           st_in.status = ST_BAD_CHANNELS;
                           st_in.phase  = PH_END;
                        end else if (cur.skip_count != '0) begin
                           st_in.phase = PH_FMT_SKIP;
                        end else if (hdr_past_end) begin
                           st_in.status = ST_NO_DATA;
                           st_in.phase  = PH_END;
                        end else begin
                           st_in.phase      = PH_TAG;
                           st_in.skip_count = CHUNK_FIELD_BYTES;
                        end
                     end
                  end
                  default: ;
               endcase
            end
            PH_FMT_SKIP, PH_SKIP: begin
               st_in.skip_count = skip_dec;
               if (skip_dec == '0) begin
                  if (hdr_past_end) begin
                     st_in.status = ST_NO_DATA;
                     st_in.phase  = PH_END;
                  end else begin
                     st_in.phase      = PH_TAG;
                     st_in.skip_count = CHUNK_FIELD_BYTES;
                  end
               end
            end
            PH_TAG: begin
               st_in.skip_count = skip_dec;
               if (skip_dec == '0) begin
                  st_in.phase      = (acc == TAG_DATA) ? PH_SIZE_DATA : PH_SIZE_OTHER;
                  st_in.skip_count = CHUNK_FIELD_BYTES;
               end
            end
            PH_SIZE_DATA, PH_SIZE_OTHER: begin
               st_in.skip_count = skip_dec;
               if (skip_dec == '0) begin
                  if (cur.phase == PH_SIZE_DATA) begin
                     st_in.phase = PH_END;
                     if (acc == '0) begin
                        st_in.status = ST_NO_DATA;
                     end else begin
                        st_in.data_offset = pos_next;
                        st_in.data_size   = acc;
                        st_in.status      = ST_DONE;
                     end
                  end else if (acc == '0) begin
                     if (hdr_past_end) begin
                        st_in.status = ST_NO_DATA;
                        st_in.phase  = PH_END;
                     end else begin
                        st_in.phase      = PH_TAG;
                        st_in.skip_count = CHUNK_FIELD_BYTES;
                     end
                  end else begin
                     // pad odd chunks, saturating at all ones
                     st_in.skip_count = (acc[0] && acc != '1) ? acc + 32'd1 : acc;
                     st_in.phase      = PH_SKIP;
                  end
               end
            end
            default: begin
               st_in.status = ST_NO_DATA;
               st_in.phase  = PH_END;
            end
         endcase
         st_in.byte_pos = pos_next;
         if (q_out.entry.last_byte && st_in.status == ST_BUSY) begin
            st_in.status = ST_NO_DATA;
            st_in.phase  = PH_END;
         end
      end

      done = (st_in.status == ST_DONE);
      res_in.status         = st_in.status;
      res_in.sample_format  = !done ? SF_PCM8 :
                              (st_in.format_code == FMT_ADPCM) ? SF_ADPCM :
                              (st_in.bits == BITS_16) ? SF_PCM16 : SF_PCM8;
      res_in.is_stereo      = done && (st_in.channel_count == MAX_CHANNELS);
      res_in.rate_hz        = st_in.rate;
      res_in.align_bytes    = st_in.align;
      res_in.bits_each      = st_in.bits;
      res_in.payload_offset = done ? st_in.data_offset : '0;
      res_in.payload_length = done ? st_in.data_size : '0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      adpcm_enable_in = csr_write_en ? csr_write_data : adpcm_enable_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff           <= STATE_RESET;
         rsp_valid_ff    <= 1'b0;
         adpcm_enable_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            st_ff <= st_in;
         end
         rsp_valid_ff    <= rsp_valid_in;
         adpcm_enable_ff <= adpcm_enable_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         res_ff <= res_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = res_ff.status;
   assign rsp.sample_format  = res_ff.sample_format;
   assign rsp.is_stereo      = res_ff.is_stereo;
   assign rsp.rate_hz        = res_ff.rate_hz;
   assign rsp.align_bytes    = res_ff.align_bytes;
   assign rsp.bits_each      = res_ff.bits_each;
   assign rsp.payload_offset = res_ff.payload_offset;
   assign rsp.payload_length = res_ff.payload_length;

endmodule

// ----- hw/rtl/wav_header_parser.sv -----
// ----------------------------------------------------------------------------
// wav_header_parser
// byte-stream riff/wave header parser with one status result per byte
// ----------------------------------------------------------------------------
//
//   channel    dir   handshake          contents
//   req_chan   in    valid/ready        file_byte, first_byte, last_byte
//   rsp_chan   out   valid/ready        status, format, stereo, fmt fields,
//                                       data offset and length
//   csr_*      in    write enable only  adpcm_enable
//
// one byte is parsed per clock unless the result side stalls; a transfer can then follow every cycle
// a request transfer fills a queue slot, and the engine loads the result
// register from that slot once it is the queue head
// the parse engine advances only when the result register is empty or drained,
// so a stalled result side fills the queue and then drops req ready
// reset is synchronous; it clears the queue, the parse state and adpcm_enable
//
`include "wav_header_parser_defines.svh"

module wav_header_parser #(
   parameter int QUEUE_DEPTH = whp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic        csr_write_data,
   whp_req_if.sink     req_chan,
   whp_rsp_if.source   rsp_chan
);
   import whp_pkg::*;

   // queue head toward the parse engine
   whp_qout_type q_out;
   logic         q_pop;

   // front end: byte transfers land in a short queue
   whp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .q_out (q_out),
      .q_pop (q_pop)
   );

   // back end: header state machine and result register
   whp_parse u_parse (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .q_out          (q_out),
      .q_pop          (q_pop),
      .rsp            (rsp_chan)
   );

   // engine only consumes a byte the queue actually holds
   `WHP_ASSERT_IMPL(a_pop_has_data, clock, reset, q_pop, q_out.valid)

   // a held result must not be overwritten by a new byte
   `WHP_ASSERT_IMPL(a_no_pop_on_stall, clock, reset,
      rsp_chan.valid && !rsp_chan.ready, !q_pop)

   // after a byte is accepted, the queue holds a valid head next cycle
   `WHP_ASSERT_NEXT(a_push_visible, clock, reset,
      req_chan.valid && req_chan.ready, q_out.valid)

   // every byte taken by the engine shows up as a result next cycle
   `WHP_ASSERT_NEXT(a_pop_gives_result, clock, reset, q_pop, rsp_chan.valid)

endmodule

// ----- test/tb_wav_header_parser.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wav_header_parser
// streams generated wav files byte by byte into the header parser and
// checks the per-byte status result against a cycle-free tracker of the parse
// ----------------------------------------------------------------------------
module tb_wav_header_parser;
   import whp_pkg::*;

   // tracks the parse of the byte stream and holds the expected status words
   class wav_header_tracker;
      logic           adpcm_on;
      logic [2:0]     parse_phase;
      logic [31:0]    byte_pos;
      logic [31:0]    shift_word;
      logic [31:0]    riff_len;
      logic [31:0]    bytes_left;
      logic [15:0]    fmt_code;
      logic [15:0]    chan_count;
      logic [31:0]    rate_val;
      logic [15:0]    align_val;
      logic [15:0]    bits_val;
      logic [31:0]    data_off;
      logic [31:0]    data_len;
      logic [3:0]     status_val;
      whp_result_type pending_status[$];
      int             errors;

      function new();
         adpcm_on = 1'b0;
         errors   = 0;
         restart();
      endfunction

      // parse state back to the start, the adpcm setting stays
      function void restart();
         parse_phase = PH_HEADER;
         byte_pos    = '0;
         shift_word  = '0;
         riff_len    = '0;
         bytes_left  = '0;
         fmt_code    = '0;
         chan_count  = '0;
         rate_val    = '0;
         align_val   = '0;
         bits_val    = '0;
         data_off    = '0;
         data_len    = '0;
         status_val  = ST_BUSY;
      endfunction

      function logic [31:0] next_pos();
         return (byte_pos == 32'hFFFF_FFFF) ? byte_pos : byte_pos + 32'd1;
      endfunction

      function void finish_parse(logic [3:0] st);
         status_val  = st;
         parse_phase = PH_END;
      endfunction

      // odd chunks carry one pad byte, saturating at the top
      function logic [31:0] with_pad(logic [31:0] n);
         logic [32:0] s;
         s = {1'b0, n} + {32'd0, n[0]};
         return s[32] ? 32'hFFFF_FFFF : s[31:0];
      endfunction

      // a chunk header past the end of the riff payload means no data
      function void open_chunk();
         if ({1'b0, next_pos()} >= {1'b0, riff_len} + RIFF_HEADER_BYTES) begin
            finish_parse(ST_NO_DATA);
         end else begin
            parse_phase = PH_TAG;
            bytes_left  = CHUNK_FIELD_BYTES;
         end
      endfunction

      function void check_fmt();
         if (fmt_code == FMT_PCM) begin
            if (bits_val != BITS_8 && bits_val != BITS_16) begin
               finish_parse(ST_BAD_BITS);
               return;
            end
         end else if (fmt_code == FMT_ADPCM && adpcm_on) begin
            if (bits_val != BITS_4) begin
               finish_parse(ST_BAD_BITS);
               return;
            end
         end else begin
            finish_parse(ST_BAD_FORMAT);
            return;
         end
         if (chan_count > MAX_CHANNELS) begin
            finish_parse(ST_BAD_CHANNELS);
            return;
         end
         if (bytes_left == 0) open_chunk();
         else parse_phase = PH_FMT_SKIP;
      endfunction

      function void header_byte();
         case (byte_pos)
            POS_RIFF_TAG:  if (shift_word != TAG_RIFF) finish_parse(ST_BAD_RIFF);
            POS_RIFF_SIZE: riff_len = shift_word;
            POS_WAVE_TAG:  if (shift_word != TAG_WAVE) finish_parse(ST_BAD_WAVE);
            POS_FMT_TAG:   if (shift_word != TAG_FMT) finish_parse(ST_BAD_FMT);
            POS_FMT_SIZE: begin
               if (shift_word < FMT_MIN_SIZE) finish_parse(ST_BAD_FMT);
               else bytes_left = with_pad(shift_word - FMT_MIN_SIZE);
            end
            POS_FORMAT:    fmt_code = shift_word[31:16];
            POS_CHANNELS:  chan_count = shift_word[31:16];
            POS_RATE:      rate_val = shift_word;
            POS_ALIGN:     align_val = shift_word[31:16];
            POS_BITS: begin
               bits_val = shift_word[31:16];
               check_fmt();
            end
            default: ;
         endcase
      endfunction

      function void size_byte();
         bytes_left = bytes_left - 32'd1;
         if (bytes_left != 0) return;
         if (parse_phase == PH_SIZE_DATA) begin
            if (shift_word == 0) begin
               finish_parse(ST_NO_DATA);
            end else begin
               data_off = next_pos();
               data_len = shift_word;
               finish_parse(ST_DONE);
            end
         end else begin
            bytes_left = with_pad(shift_word);
            if (bytes_left == 0) open_chunk();
            else parse_phase = PH_SKIP;
         end
      endfunction

      // one accepted byte, one expected status word
      function void take_byte(logic [7:0] b, logic first, logic last);
         whp_result_type r;
         logic           done;
         if (first) restart();
         if (parse_phase != PH_END) begin
            shift_word = {b, shift_word[31:8]};
            case (parse_phase)
               PH_HEADER: header_byte();
               PH_FMT_SKIP, PH_SKIP: begin
                  bytes_left = bytes_left - 32'd1;
                  if (bytes_left == 0) open_chunk();
               end
               PH_TAG: begin
                  bytes_left = bytes_left - 32'd1;
                  if (bytes_left == 0) begin
                     parse_phase = (shift_word == TAG_DATA) ? PH_SIZE_DATA : PH_SIZE_OTHER;
                     bytes_left  = CHUNK_FIELD_BYTES;
                  end
               end
               PH_SIZE_DATA, PH_SIZE_OTHER: size_byte();
               default: finish_parse(ST_NO_DATA);
            endcase
            byte_pos = next_pos();
            if (last && status_val == ST_BUSY) finish_parse(ST_NO_DATA);
         end
         done = (status_val == ST_DONE);
         r.status = status_val;
         if (!done) r.sample_format = SF_PCM8;
         else if (fmt_code == FMT_ADPCM) r.sample_format = SF_ADPCM;
         else r.sample_format = (bits_val == BITS_16) ? SF_PCM16 : SF_PCM8;
         r.is_stereo      = done && (chan_count == MAX_CHANNELS);
         r.rate_hz        = rate_val;
         r.align_bytes    = align_val;
         r.bits_each      = bits_val;
         r.payload_offset = done ? data_off : 32'd0;
         r.payload_length = done ? data_len : 32'd0;
         pending_status.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_status(whp_result_type got);
         whp_result_type want;
         if (pending_status.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, actual %p", $time, got);
            errors++;
            return;
         end
         want = pending_status.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("sample_format", want.sample_format, got.sample_format);
         compare_field("is_stereo", want.is_stereo, got.is_stereo);
         compare_field("rate_hz", want.rate_hz, got.rate_hz);
         compare_field("align_bytes", want.align_bytes, got.align_bytes);
         compare_field("bits_each", want.bits_each, got.bits_each);
         compare_field("payload_offset", want.payload_offset, got.payload_offset);
         compare_field("payload_length", want.payload_length, got.payload_length);
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_write_en;
   logic csr_write_data;

   whp_req_if req_chan ();
   whp_rsp_if rsp_chan ();

   wav_header_parser uut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan)
   );

   wav_header_tracker tracker;

   // percent of cycles where the byte source holds off / the result side stalls
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int bytes_sent     = 0;

   // the file currently being streamed
   logic [7:0] file_q[$];

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // result side: ready changes on the falling edge only
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // every result transfer is checked against the oldest expectation
   always @(posedge clock) begin : result_monitor
      whp_result_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.status         = rsp_chan.status;
         got.sample_format  = rsp_chan.sample_format;
         got.is_stereo      = rsp_chan.is_stereo;
         got.rate_hz        = rsp_chan.rate_hz;
         got.align_bytes    = rsp_chan.align_bytes;
         got.bits_each      = rsp_chan.bits_each;
         got.payload_offset = rsp_chan.payload_offset;
         got.payload_length = rsp_chan.payload_length;
         tracker.check_status(got);
      end
   end

   // run limit, far above the slowest correct run
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   // little-endian field writers for the file image
   function void put16(logic [15:0] v);
      file_q.push_back(v[7:0]);
      file_q.push_back(v[15:8]);
   endfunction

   function void put32(logic [31:0] v);
      put16(v[15:0]);
      put16(v[31:16]);
   endfunction

   // riff header, fmt chunk (with its tail and pad), some other chunks, then
   // the data chunk header and a few sample bytes that the parser ignores
   function void build_wav(logic [15:0] fmt, logic [15:0] chans, logic [15:0] bits_n,
                           logic [31:0] rate, logic [15:0] align_n, logic [31:0] fmt_len,
                           logic [31:0] riff_len, logic [31:0] data_len, int n_other);
      logic [31:0] tag;
      int          sz;
      file_q.delete();
      put32(TAG_RIFF);
      put32(riff_len);
      put32(TAG_WAVE);
      put32(TAG_FMT);
      put32(fmt_len);
      put16(fmt);
      put16(chans);
      put32(rate);
      put32($urandom);
      put16(align_n);
      put16(bits_n);
      if (fmt_len > FMT_MIN_SIZE && fmt_len < 64)
         repeat (fmt_len - FMT_MIN_SIZE + fmt_len[0]) file_q.push_back(8'($urandom));
      repeat (n_other) begin
         tag = $urandom;
         if (tag == TAG_DATA) tag = ~tag;
         sz = $urandom_range(9);
         put32(tag);
         put32(sz);
         repeat (sz + sz % 2) file_q.push_back(8'($urandom));
      end
      put32(TAG_DATA);
      put32(data_len);
      repeat ($urandom_range(3)) file_q.push_back(8'($urandom));
   endfunction

   // one byte transfer; called at a falling edge, returns at a falling edge
   // with valid still high so back-to-back bytes need no gap
   task automatic send_byte(logic [7:0] b, logic first, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid      = 1'b1;
      req_chan.file_byte  = b;
      req_chan.first_byte = first;
      req_chan.last_byte  = last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      tracker.take_byte(b, first, last);
      bytes_sent++;
      @(negedge clock);
   endtask

   // stream the first n bytes of the file, optionally flagging the final one
   task automatic send_file(bit with_first, int n, bit mark_last);
      int stop;
      stop = (n < file_q.size()) ? n : file_q.size();
      for (int i = 0; i < stop; i++)
         send_byte(file_q[i], with_first && i == 0, mark_last && i == stop - 1);
   endtask

   // register write only once every expected result has come back
   task automatic write_adpcm(logic v);
      req_chan.valid = 1'b0;
      while (tracker.pending_status.size() != 0) @(negedge clock);
      csr_write_en   = 1'b1;
      csr_write_data = v;
      @(negedge clock);
      csr_write_en     = 1'b0;
      tracker.adpcm_on = v;
   endtask

   // mostly well-formed files with random content, plus corrupted,
   // truncated and unflagged files and plain noise
   task automatic random_files(int target);
      int          start;
      int          roll;
      int          r;
      int          n;
      bit          mark_last;
      logic [15:0] fmt;
      logic [15:0] chans;
      logic [15:0] bits_n;
      logic [31:0] fmt_len;
      logic [31:0] riff_len;
      logic [31:0] data_len;
      start = bytes_sent;
      while (bytes_sent - start < target) begin
         roll = $urandom_range(99);
         if (roll < 8) begin
            // noise with random restart and end flags
            repeat ($urandom_range(1, 12))
               send_byte(8'($urandom), $urandom_range(9) == 0, $urandom_range(9) == 0);
         end else begin
            r = $urandom_range(9);
            fmt = (r < 6) ? FMT_PCM : (r < 9) ? FMT_ADPCM : 16'($urandom);
            r = $urandom_range(9);
            if (fmt == FMT_ADPCM)
               bits_n = (r < 8) ? BITS_4 : (r == 8) ? BITS_8 : 16'($urandom);
            else
               bits_n = (r < 4) ? BITS_8 : (r < 8) ? BITS_16 : 16'($urandom_range(32));
            r = $urandom_range(9);
            chans = (r < 4) ? 16'd1 : (r < 8) ? 16'd2 : (r == 8) ? 16'd0
                                                            : 16'($urandom_range(3, 65535));
            r = $urandom_range(9);
            fmt_len = (r < 7) ? FMT_MIN_SIZE : (r < 9) ? $urandom_range(17, 22)
                                                       : $urandom_range(15);
            riff_len = ($urandom_range(9) < 9) ? ($urandom | 32'h100) : $urandom_range(60);
            data_len = ($urandom_range(9) < 9) ? $urandom : 32'd0;
            build_wav(fmt, chans, bits_n, $urandom, 16'($urandom), fmt_len, riff_len,
                      data_len, $urandom_range(2));
            n         = file_q.size();
            mark_last = ($urandom_range(9) < 3);
            if (roll < 20) begin
               // one byte overwritten anywhere
               file_q[$urandom_range(file_q.size() - 1)] = 8'($urandom);
            end else if (roll < 30) begin
               // stream cut short
               n         = $urandom_range(1, file_q.size() - 1);
               mark_last = 1'b1;
            end
            send_file($urandom_range(19) != 0, n, mark_last);
         end
      end
   endtask

   initial begin
      tracker             = new();
      reset               = 1'b1;
      csr_write_en        = 1'b0;
      csr_write_data      = 1'b0;
      req_chan.valid      = 1'b0;
      req_chan.file_byte  = 8'h00;
      req_chan.first_byte = 1'b0;
      req_chan.last_byte  = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---- directed files, adpcm off ----
      write_adpcm(1'b0);
      // pcm 8 mono straight after reset with no restart flag, top rate and align
      build_wav(FMT_PCM, 16'd1, BITS_8, 32'hFFFF_FFFF, 16'hFFFF, FMT_MIN_SIZE,
                32'h0010_0000, 32'h100, 0);
      send_file(1'b0, file_q.size(), 1'b0);
      // pcm 16 stereo, odd fmt tail with pad, two other chunks, largest data size
      build_wav(FMT_PCM, 16'd2, BITS_16, 32'd0, 16'd0, 32'd19, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 2);
      send_file(1'b1, file_q.size(), 1'b0);
      // bad riff tag
      build_wav(FMT_PCM, 16'd1, BITS_8, 32'd8000, 16'd1, FMT_MIN_SIZE, 32'h1000, 32'd10, 0);
      file_q[0] = 8'h00;
      send_file(1'b1, file_q.size(), 1'b0);
      // bad wave tag
      build_wav(FMT_PCM, 16'd1, BITS_8, 32'd8000, 16'd1, FMT_MIN_SIZE, 32'h1000, 32'd10, 0);
      file_q[8] = file_q[8] ^ 8'h01;
      send_file(1'b1, file_q.size(), 1'b0);
      // bad fmt tag
      build_wav(FMT_PCM, 16'd1, BITS_8, 32'd8000, 16'd1, FMT_MIN_SIZE, 32'h1000, 32'd10, 0);
      file_q[15] = file_q[15] ^ 8'h80;
      send_file(1'b1, file_q.size(), 1'b0);
      // fmt chunk too short
      build_wav(FMT_PCM, 16'd1, BITS_8, 32'd8000, 16'd1, 32'd15, 32'h1000, 32'd10, 0);
      send_file(1'b1, file_q.size(), 1'b0);
      // pcm with unsupported bit depth, then the largest bit count
      build_wav(FMT_PCM, 16'd1, 16'd12, 32'd8000, 16'd2, FMT_MIN_SIZE, 32'h1000, 32'd10, 0);
      send_file(1'b1, file_q.size(), 1'b0);
      build_wav(FMT_PCM, 16'd1, 16'hFFFF, 32'd8000, 16'd2, FMT_MIN_SIZE, 32'h1000, 32'd10, 0);
      send_file(1'b1, file_q.size(), 1'b0);
      // adpcm while it is disabled, and an unknown format code
      build_wav(FMT_ADPCM, 16'd1, BITS_4, 32'd8000, 16'd256, FMT_MIN_SIZE, 32'h1000,
                32'd10, 0);
      send_file(1'b1, file_q.size(), 1'b0);
      build_wav(16'hFFFF, 16'd1, BITS_8, 32'd8000, 16'd1, FMT_MIN_SIZE, 32'h1000, 32'd10, 0);
      send_file(1'b1, file_q.size(), 1'b0);
      // too many channels, three and the largest count
      build_wav(FMT_PCM, 16'd3, BITS_16, 32'd8000, 16'd6, FMT_MIN_SIZE, 32'h1000, 32'd10, 0);
      send_file(1'b1, file_q.size(), 1'b0);
      build_wav(FMT_PCM, 16'hFFFF, BITS_16, 32'd8000, 16'd6, FMT_MIN_SIZE, 32'h1000,
                32'd10, 0);
      send_file(1'b1, file_q.size(), 1'b0);
      // empty data chunk
      build_wav(FMT_PCM, 16'd0, BITS_8, 32'd8000, 16'd1, FMT_MIN_SIZE, 32'h1000, 32'd0, 1);
      send_file(1'b1, file_q.size(), 1'b0);
      // riff size ends right after the fmt chunk, so no data chunk is reached
      build_wav(FMT_PCM, 16'd1, BITS_8, 32'd8000, 16'd1, FMT_MIN_SIZE, 32'd28, 32'd10, 0);
      send_file(1'b1, file_q.size(), 1'b0);
      // riff size ends inside an other chunk
      build_wav(FMT_PCM, 16'd1, BITS_8, 32'd8000, 16'd1, FMT_MIN_SIZE, 32'd40, 32'd10, 2);
      send_file(1'b1, file_q.size(), 1'b0);
      // stream ends in the middle of the fmt chunk
      build_wav(FMT_PCM, 16'd1, BITS_8, 32'd8000, 16'd1, FMT_MIN_SIZE, 32'h1000, 32'd10, 0);
      send_file(1'b1, 26, 1'b1);
      // restart in the middle of a file, then a full file
      build_wav(FMT_PCM, 16'd2, BITS_16, 32'd44100, 16'd4, FMT_MIN_SIZE, 32'h1000, 32'd9, 0);
      send_file(1'b1, 20, 1'b0);
      build_wav(FMT_PCM, 16'd2, BITS_16, 32'd44100, 16'd4, FMT_MIN_SIZE, 32'h1000, 32'd9, 1);
      send_file(1'b1, file_q.size(), 1'b1);
      // end flag on the very byte that completes the parse
      build_wav(FMT_PCM, 16'd1, BITS_8, 32'd22050, 16'd1, FMT_MIN_SIZE, 32'h1000, 32'd7, 0);
      send_file(1'b1, 44, 1'b1);

      // ---- directed files, adpcm on ----
      write_adpcm(1'b1);
      build_wav(FMT_ADPCM, 16'd2, BITS_4, 32'd32000, 16'd512, 32'd20, 32'h1000, 32'd333, 1);
      send_file(1'b1, file_q.size(), 1'b0);
      build_wav(FMT_ADPCM, 16'd1, BITS_8, 32'd32000, 16'd256, FMT_MIN_SIZE, 32'h1000,
                32'd10, 0);
      send_file(1'b1, file_q.size(), 1'b0);
      build_wav(FMT_PCM, 16'd1, BITS_16, 32'd48000, 16'd2, FMT_MIN_SIZE, 32'h1000, 32'd10, 0);
      send_file(1'b1, file_q.size(), 1'b0);

      // ---- random files: four idling modes, adpcm off and on in turn ----
      for (int ph = 0; ph < 4; ph++) begin
         write_adpcm(ph % 2 == 1);
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
         endcase
         random_files(30);
      end

      // drain: all results back, then a few more cycles for strays
      req_chan.valid = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      while (tracker.pending_status.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
